// File: rtl/lcfb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Locomotive command frame builder package
// Shared types and byte constants for the command frame builder.
// ----------------------------------------------------------------------------
package lcfb_pkg;

    // Request kinds.
    localparam logic [3:0] REQ_ESTOP   = 4'd0;
    localparam logic [3:0] REQ_SPEED   = 4'd1;
    localparam logic [3:0] REQ_FUNC_G1 = 4'd2;
    localparam logic [3:0] REQ_FUNC_G2 = 4'd3;
    localparam logic [3:0] REQ_FUNC_G3 = 4'd4;
    localparam logic [3:0] REQ_STATE_G1 = 4'd5;
    localparam logic [3:0] REQ_STATE_G2 = 4'd6;
    localparam logic [3:0] REQ_STATE_G3 = 4'd7;
    localparam logic [3:0] REQ_F13_F20 = 4'd8;

    // Frame bytes.
    localparam logic [7:0] HDR_ESTOP      = 8'h92;
    localparam logic [7:0] HDR_LONG       = 8'hE4;
    localparam logic [7:0] ADDR_LONG_MARK = 8'hC0;
    localparam logic [13:0] SHORT_ADDR_MAX = 14'd99;
    localparam logic [7:0] DIR_FORWARD    = 8'h80;
    localparam logic [7:0] ESTOP_CODE     = 8'h01;
    localparam logic [7:0] ID_SPEED_BASE  = 8'h10;
    localparam logic [7:0] ID_FUNC_BASE   = 8'h1F;
    localparam logic [7:0] ID_STATE_BASE  = 8'h23;
    localparam logic [7:0] ID_F13_F20     = 8'hF3;

    // Byte counts, checksum included.
    localparam logic [2:0] COUNT_ESTOP = 3'd4;
    localparam logic [2:0] COUNT_LONG  = 3'd6;

    typedef struct packed {
        logic [3:0]  req_type;
        logic [13:0] loco_address;
        logic [1:0]  speed_mode;
        logic [6:0]  speed_value;
        logic        estop_flag;
        logic        forward_flag;
        logic [20:0] function_on;
        logic [12:0] function_momentary;
    } t_req;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } t_result;

    typedef logic [5:0][7:0] t_frame_bytes;

    typedef struct packed {
        logic         valid;
        logic [2:0]   count;
        t_frame_bytes bytes;
    } t_frame;

endpackage
`default_nettype wire

// File: rtl/lcfb_frame_encode.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame encoder
// Builds the complete frame, checksum included, for one registered request.
// ----------------------------------------------------------------------------
module lcfb_frame_encode (
    input  var lcfb_pkg::t_req   i_req,
    output lcfb_pkg::t_frame     o_frame
);

    function automatic logic [7:0] speed_byte(logic [1:0] mode, logic [6:0] step,
                                              logic estop, logic fwd);
        logic [6:0] lim;
        logic [6:0] s;
        logic [4:0] v;
        logic [7:0] code;
        case (mode)
            2'd0:    lim = 7'd14;
            2'd1:    lim = 7'd27;
            2'd2:    lim = 7'd28;
            default: lim = 7'd126;
        endcase
        s    = (step > lim) ? lim : step;
        v    = 5'(s + 7'd3);
        code = '0;
        if (estop) begin
            code = lcfb_pkg::ESTOP_CODE;
        end else if (s != 7'd0) begin
            if (mode == 2'd1 || mode == 2'd2) begin
                // 28 step layout: lowest bit of the value goes to bit 4.
                code = {3'b000, v[0], v[4:1]};
            end else begin
                code = {1'b0, 7'(s + 7'd1)};
            end
        end
        if (fwd) begin
            code = code | lcfb_pkg::DIR_FORWARD;
        end
        return code;
    endfunction

    function automatic logic [7:0] group_bits(logic [12:0] f, logic [1:0] group);
        logic [7:0] b;
        case (group)
            2'd1:    b = {3'b000, f[0], f[4:1]};
            2'd2:    b = {4'b0000, f[8:5]};
            default: b = {4'b0000, f[12:9]};
        endcase
        return b;
    endfunction

    logic [7:0] addr_hi;
    logic [7:0] addr_lo;
    logic [7:0] ident;
    logic [7:0] payload;
    logic       long_frame;
    logic       known;

    always_comb begin
        addr_lo = i_req.loco_address[7:0];
        if (i_req.loco_address <= lcfb_pkg::SHORT_ADDR_MAX) begin
            addr_hi = 8'h00;
        end else begin
            addr_hi = lcfb_pkg::ADDR_LONG_MARK | {2'b00, i_req.loco_address[13:8]};
        end

        ident      = '0;
        payload    = '0;
        long_frame = 1'b1;
        known      = 1'b1;
        unique case (i_req.req_type) inside
            lcfb_pkg::REQ_ESTOP: begin
                long_frame = 1'b0;
            end
            lcfb_pkg::REQ_SPEED: begin
                ident   = lcfb_pkg::ID_SPEED_BASE | {6'd0, i_req.speed_mode};
                payload = speed_byte(i_req.speed_mode, i_req.speed_value,
                                     i_req.estop_flag, i_req.forward_flag);
            end
            lcfb_pkg::REQ_FUNC_G1, lcfb_pkg::REQ_FUNC_G2, lcfb_pkg::REQ_FUNC_G3: begin
                ident   = 8'(lcfb_pkg::ID_FUNC_BASE + {4'd0, i_req.req_type} - 8'd1);
                payload = group_bits(i_req.function_on[12:0],
                                     2'(i_req.req_type - lcfb_pkg::REQ_ESTOP - 4'd1));
            end
            lcfb_pkg::REQ_STATE_G1, lcfb_pkg::REQ_STATE_G2, lcfb_pkg::REQ_STATE_G3: begin
                ident   = 8'(lcfb_pkg::ID_STATE_BASE + {4'd0, i_req.req_type} - 8'd4);
                payload = group_bits(i_req.function_momentary,
                                     2'(i_req.req_type - 4'd4));
            end
            lcfb_pkg::REQ_F13_F20: begin
                ident   = lcfb_pkg::ID_F13_F20;
                payload = i_req.function_on[20:13];
            end
            default: begin
                known = 1'b0;
            end
        endcase

        o_frame.valid = known;
        if (long_frame) begin
            o_frame.count    = lcfb_pkg::COUNT_LONG;
            o_frame.bytes[0] = lcfb_pkg::HDR_LONG;
            o_frame.bytes[1] = ident;
            o_frame.bytes[2] = addr_hi;
            o_frame.bytes[3] = addr_lo;
            o_frame.bytes[4] = payload;
            o_frame.bytes[5] = lcfb_pkg::HDR_LONG ^ ident ^ addr_hi ^ addr_lo ^ payload;
        end else begin
            o_frame.count    = lcfb_pkg::COUNT_ESTOP;
            o_frame.bytes[0] = lcfb_pkg::HDR_ESTOP;
            o_frame.bytes[1] = addr_hi;
            o_frame.bytes[2] = addr_lo;
            o_frame.bytes[3] = lcfb_pkg::HDR_ESTOP ^ addr_hi ^ addr_lo;
            o_frame.bytes[4] = 8'h00;
            o_frame.bytes[5] = 8'h00;
        end
    end

endmodule
`default_nettype wire

// File: rtl/lcfb_byte_serializer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Byte serialiser
// Holds one built frame and shifts it out, one byte per cycle.
// ----------------------------------------------------------------------------
module lcfb_byte_serializer (
    input  var logic              i_clk,
    input  var logic              i_rst_n,
    input  var logic              i_load,
    input  var lcfb_pkg::t_frame  i_frame,
    output logic                  o_ready,
    output logic                  o_strobe,
    output lcfb_pkg::t_result     o_result
);

    lcfb_pkg::t_frame_bytes r_bytes;
    lcfb_pkg::t_frame_bytes n_bytes;
    logic [2:0]             r_left;
    logic [2:0]             n_left;

    // A new frame may enter while the final byte of the current one is shown.
    assign o_ready = (r_left == 3'd0) || (r_left == 3'd1);

    always_comb begin
        if (i_load) begin
            n_bytes = i_frame.bytes;
            n_left  = i_frame.count;
        end else begin
            n_bytes = r_bytes >> 8;
            n_left  = (r_left == 3'd0) ? 3'd0 : 3'(r_left - 3'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else begin
            r_left <= n_left;
        end
        r_bytes <= n_bytes;
    end

    assign o_strobe           = (r_left != 3'd0);
    assign o_result.out_byte  = r_bytes[0];
    assign o_result.last_byte = (r_left == 3'd1);

endmodule
`default_nettype wire

// File: rtl/loco_command_frame_builder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Locomotive command frame builder
// Turns one locomotive command request into its command frame bytes.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake            | Payload           | Transaction
//  ---------+----------------------+-------------------+----------------------------
//  request  | start in, busy out   | i_req (t_req)     | start high while busy is low
//  result   | o_strobe out         | o_result          | every cycle with o_strobe
//
//  A request transaction is held in the request register while the encoder
//  builds the whole frame and its checksum. The frame then loads into the
//  serialiser, which presents one byte per cycle: four bytes for an
//  emergency stop frame and six for any other. Requests of an unknown kind
//  are dropped and produce no bytes. Reset is synchronous and clears the
//  valid flag of the request register and the byte count of the serialiser.
//  The receiver cannot stall, so busy only reflects a request waiting for
//  the serialiser to free.
//
// ----------------------------------------------------------------------------
module loco_command_frame_builder (
    input  var logic               i_clk,
    input  var logic               i_rst_n,
    input  var logic               start,
    output logic                   busy,
    input  var lcfb_pkg::t_req     i_req,
    output logic                   o_strobe,
    output lcfb_pkg::t_result      o_result
);

    // Request register: one accepted transaction waiting to be encoded.
    lcfb_pkg::t_req   r_req;
    logic             r_req_valid;
    logic             n_req_valid;

    lcfb_pkg::t_frame w_frame;
    logic             w_ser_ready;
    logic             w_advance;
    logic             w_load;

    lcfb_frame_encode u_encode (
        .i_req   (r_req),
        .o_frame (w_frame)
    );

    // A request leaves the register when its frame is taken by the serialiser,
    // or at once when its kind is unknown and it yields no frame.
    assign w_advance = r_req_valid && (!w_frame.valid || w_ser_ready);
    assign w_load    = r_req_valid && w_frame.valid && w_ser_ready;
    assign busy      = r_req_valid && !w_advance;

    always_comb begin
        if (start && !busy) begin
            n_req_valid = 1'b1;
        end else if (w_advance) begin
            n_req_valid = 1'b0;
        end else begin
            n_req_valid = r_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else begin
            r_req_valid <= n_req_valid;
        end
        if (start && !busy) begin
            r_req <= i_req;
        end
    end

    lcfb_byte_serializer u_serializer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_load),
        .i_frame  (w_frame),
        .o_ready  (w_ser_ready),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule
`default_nettype wire
